// File: hdl/bf_fft_pkg.sv
// Shared constants, codes and controller/datapath command types for the
// block floating point FFT. No dependencies.
`default_nettype none
package bf_fft_pkg;

  localparam int LOG2_MAX_POINTS = 10;
  localparam int AW              = LOG2_MAX_POINTS;
  localparam int DEPTH           = 1 << LOG2_MAX_POINTS;
  localparam logic [3:0] LG_MAX  = 4'(LOG2_MAX_POINTS);

  typedef enum logic [1:0] {
    OP_LOAD_SAMPLE  = 2'd0,
    OP_LOAD_TWIDDLE = 2'd1,
    OP_RUN          = 2'd2,
    OP_READ         = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    WS_LOAD = 2'd0,
    WS_SUM  = 2'd1,
    WS_DIFF = 2'd2
  } wsel_e;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [0:0] REG_DIRECTION   = 1'b0;
  localparam logic [0:0] REG_LOG2_POINTS = 1'b1;

  typedef struct packed {
    logic          s_we;
    logic [AW-1:0] s_waddr;
    wsel_e         wsel;
    logic [AW-1:0] s_raddr;
    logic          t_we;
    logic [AW-1:0] t_waddr;
    logic [AW-1:0] t_raddr;
    logic          cap_a;
    logic          cap_b;
    logic          cap_prod;
    logic          scan_clr;
    logic          scan_chk;
    logic          stage_lat;
    logic          cnt_clr;
    logic          inv;
  } cmd_t;

  typedef struct packed {
    logic       big;
    logic [3:0] shift_total;
  } status_t;

  // Wrap a 10-bit index onto the store address width.
  function automatic logic [AW-1:0] wrap_idx(input logic [9:0] x);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < AW; i++) begin
      if (i < 10) r[i] = x[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/bf_fft_if.sv
// Handshake channel interfaces: command word in, result word out, config write.
// Depends on nothing.
`default_nettype none
interface bf_fft_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [9:0]         index;
  logic signed [15:0] value_re;
  logic signed [15:0] value_im;
  modport source (output valid, opcode, index, value_re, value_im, input ready);
  modport sink   (input valid, opcode, index, value_re, value_im, output ready);
endinterface

interface bf_fft_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [15:0] out_re;
  logic signed [15:0] out_im;
  logic [3:0]         stage_shifts;
  modport source (output valid, result_kind, out_re, out_im, stage_shifts, input ready);
  modport sink   (input valid, result_kind, out_re, out_im, stage_shifts, output ready);
endinterface

interface bf_fft_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [3:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/bf_fft_dp.sv
// Datapath: sample and twiddle memories, peak scan, butterfly arithmetic and
// shift count. Depends on bf_fft_pkg.
`default_nettype none
module bf_fft_dp
  import bf_fft_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  input  wire logic signed [15:0] ld_re_i,
  input  wire logic signed [15:0] ld_im_i,
  output      logic signed [15:0] rd_re_o,
  output      logic signed [15:0] rd_im_o,
  output      status_t            status_o
);

  logic [31:0] smem [DEPTH];
  logic [31:0] tmem [DEPTH];
  logic [31:0] s_rdata_q, t_rdata_q, s_wdata;

  logic signed [15:0] a_re_q, a_im_q, w_re_q, w_im_q, sum_re_q, sum_im_q;
  logic signed [16:0] d_re_q, d_im_q;
  logic signed [32:0] p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic               big_q, sh15_q;
  logic [3:0]         cnt_q;
  logic signed [15:0] b_re, b_im, diff_re, diff_im;
  logic signed [16:0] s_re, s_im;
  logic signed [34:0] t_re, t_im;

  function automatic logic signed [15:0] rnd_sat(input logic signed [34:0] x,
                                                  input logic sh15);
    logic signed [34:0] y;
    y = sh15 ? (x + 35'sd16384) >>> 15 : (x + 35'sd8192) >>> 14;
    if (y > 35'sd32767) return 16'sd32767;
    else if (y < -35'sd32768) return -16'sd32768;
    else return y[15:0];
  endfunction

  function automatic logic peak(input logic signed [15:0] v);
    return (v >= 16'sd8192) || (v <= -16'sd8192);
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.s_we) smem[cmd_i.s_waddr] <= s_wdata;
    s_rdata_q <= smem[cmd_i.s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.t_we) tmem[cmd_i.t_waddr] <= {ld_re_i, ld_im_i};
    t_rdata_q <= tmem[cmd_i.t_raddr];
  end

  assign rd_re_o = s_rdata_q[31:16];
  assign rd_im_o = s_rdata_q[15:0];
  assign b_re    = s_rdata_q[31:16];
  assign b_im    = s_rdata_q[15:0];
  assign s_re    = 17'(a_re_q) + 17'(b_re);
  assign s_im    = 17'(a_im_q) + 17'(b_im);

  // Conjugate twiddle for forward, plain twiddle for inverse.
  assign t_re = cmd_i.inv ? 35'(p_rr_q) - 35'(p_ii_q) : 35'(p_rr_q) + 35'(p_ii_q);
  assign t_im = cmd_i.inv ? 35'(p_ir_q) + 35'(p_ri_q) : 35'(p_ir_q) - 35'(p_ri_q);
  assign diff_re = rnd_sat(t_re, sh15_q);
  assign diff_im = rnd_sat(t_im, sh15_q);

  always_comb begin
    unique case (cmd_i.wsel)
      WS_LOAD: s_wdata = {ld_re_i, ld_im_i};
      WS_SUM:  s_wdata = {sum_re_q, sum_im_q};
      WS_DIFF: s_wdata = {diff_re, diff_im};
      default: s_wdata = {ld_re_i, ld_im_i};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      a_re_q <= b_re;
      a_im_q <= b_im;
      w_re_q <= t_rdata_q[31:16];
      w_im_q <= t_rdata_q[15:0];
    end
    if (cmd_i.cap_b) begin
      d_re_q   <= 17'(a_re_q) - 17'(b_re);
      d_im_q   <= 17'(a_im_q) - 17'(b_im);
      sum_re_q <= rnd_sat({{4{s_re[16]}}, s_re, 14'd0}, sh15_q);
      sum_im_q <= rnd_sat({{4{s_im[16]}}, s_im, 14'd0}, sh15_q);
    end
    if (cmd_i.cap_prod) begin
      p_rr_q <= d_re_q * w_re_q;
      p_ii_q <= d_im_q * w_im_q;
      p_ir_q <= d_im_q * w_re_q;
      p_ri_q <= d_re_q * w_im_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_q  <= 1'b0;
      sh15_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.scan_clr) big_q <= 1'b0;
      else if (cmd_i.scan_chk && (peak(b_re) || peak(b_im))) big_q <= 1'b1;
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.stage_lat) begin
        sh15_q <= big_q;
        cnt_q  <= cnt_q + 4'(big_q);
      end
    end
  end

  assign status_o = '{big: big_q, shift_total: cnt_q};

endmodule
`default_nettype wire

// File: hdl/bf_fft_ctrl.sv
// Controller: sequences loads, reads and the stage/scan/butterfly loop of a
// run. Depends on bf_fft_pkg.
`default_nettype none
module bf_fft_ctrl
  import bf_fft_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_opcode_i,
  input  wire logic [9:0] in_index_i,
  output      logic       in_ready_o,
  input  wire logic       dir_i,
  input  wire logic [3:0] lg_i,
  input  wire logic       out_free_i,
  output      logic       out_load_o,
  output      logic       out_kind_o,
  output      cmd_t       cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_READ     = 13'b0000000000010,
    S_STAGE    = 13'b0000000000100,
    S_SCAN     = 13'b0000000001000,
    S_SCAN_END = 13'b0000000010000,
    S_LATCH    = 13'b0000000100000,
    S_RA       = 13'b0000001000000,
    S_RB       = 13'b0000010000000,
    S_DIFF     = 13'b0000100000000,
    S_PROD     = 13'b0001000000000,
    S_WA       = 13'b0010000000000,
    S_WB       = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d, half_q, half_d, j_q, j_d, tw_q, tw_d;
  logic [AW:0]   n_q, n_d, g_q, g_d, scan_q, scan_d;
  logic [3:0]    st_q, st_d, lg_sat;
  logic [AW-1:0] ia, ib, in_idx;
  logic          accept;
  opcode_e       op;

  assign op     = opcode_e'(in_opcode_i);
  assign in_idx = wrap_idx(in_index_i);
  assign accept = in_valid_i && in_ready_o;
  assign lg_sat = (lg_i > LG_MAX) ? LG_MAX : lg_i;
  assign ia     = g_q[AW-1:0] + j_q;
  assign ib     = ia + half_q;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q; half_d = half_q; j_d = j_q; tw_d = tw_q;
    n_d = n_q; g_d = g_q; scan_d = scan_q; st_d = st_q;
    out_load_o = 1'b0;
    out_kind_o = KIND_READ;
    cmd_o          = '0;
    cmd_o.wsel     = WS_LOAD;
    cmd_o.inv      = dir_i;
    cmd_o.s_waddr  = in_idx;
    cmd_o.t_waddr  = in_idx;
    cmd_o.s_raddr  = in_idx;
    cmd_o.t_raddr  = tw_q + j_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = in_idx;
          unique case (op)
            OP_LOAD_SAMPLE:  cmd_o.s_we = 1'b1;
            OP_LOAD_TWIDDLE: cmd_o.t_we = 1'b1;
            OP_READ:         state_d = S_READ;
            OP_RUN: begin
              cmd_o.cnt_clr = 1'b1;
              n_d  = (AW+1)'(1) << lg_sat;
              st_d = lg_sat;
              tw_d = '0;
              state_d = (lg_sat == 4'd0) ? S_DONE : S_STAGE;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd_o.s_raddr = idx_q;
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_STAGE: begin
        cmd_o.scan_clr = 1'b1;
        scan_d = '0;
        g_d = '0;
        j_d = '0;
        half_d = AW'(1) << (st_q - 4'd1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // Check the word issued last cycle; the first issue has nothing behind it.
        cmd_o.s_raddr  = scan_q[AW-1:0];
        cmd_o.scan_chk = (scan_q != '0);
        if (scan_q == n_q - (AW+1)'(1)) state_d = S_SCAN_END;
        else scan_d = scan_q + (AW+1)'(1);
      end
      S_SCAN_END: begin
        cmd_o.scan_chk = 1'b1;
        state_d = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.stage_lat = 1'b1;
        state_d = S_RA;
      end
      S_RA: begin
        cmd_o.s_raddr = ia;
        state_d = S_RB;
      end
      S_RB: begin
        cmd_o.s_raddr = ib;
        cmd_o.cap_a = 1'b1;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.s_raddr = ib;
        cmd_o.cap_b = 1'b1;
        state_d = S_PROD;
      end
      S_PROD: begin
        cmd_o.cap_prod = 1'b1;
        state_d = S_WA;
      end
      S_WA: begin
        cmd_o.s_we    = 1'b1;
        cmd_o.s_waddr = ia;
        cmd_o.wsel    = WS_SUM;
        state_d = S_WB;
      end
      S_WB: begin
        cmd_o.s_we    = 1'b1;
        cmd_o.s_waddr = ib;
        cmd_o.wsel    = WS_DIFF;
        state_d = S_RA;
        if ({1'b0, j_q} + (AW+1)'(1) == {1'b0, half_q}) begin
          j_d = '0;
          g_d = g_q + {half_q, 1'b0};
          if (g_q + {half_q, 1'b0} == n_q) begin
            tw_d = tw_q + half_q;
            st_d = st_q - 4'd1;
            state_d = (st_q == 4'd1) ? S_DONE : S_STAGE;
          end
        end else begin
          j_d = j_q + AW'(1);
        end
      end
      S_DONE: begin
        out_kind_o = KIND_DONE;
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= '0;
      n_q     <= '0;
      g_q     <= '0;
      j_q     <= '0;
      half_q  <= '0;
      tw_q    <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      n_q     <= n_d;
      g_q     <= g_d;
      j_q     <= j_d;
      half_q  <= half_d;
      tw_q    <= tw_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

endmodule
`default_nettype wire

// File: hdl/block_float_radix2_dif_fft.sv
// Top level of the block floating point radix-2 DIF FFT: config registers,
// result register, controller and datapath. Depends on bf_fft_pkg, bf_fft_if.
//
// Usage:
//  - in_ch carries command words: load sample, load twiddle (Q14), run, read.
//    Loads give no result; a read gives one result word (result_kind 0).
//  - A run performs log2 N stages in place. Each stage first scans all N
//    samples through the single read port, then runs N/2 butterflies, each
//    in the order read A, read B, difference, product, write A, write B, as
//    the sample memory has one read and one write port. A run ends with one
//    result word (result_kind 1, stage_shifts = halved stages).
//  - in_ch.ready is high only while no command is in progress.
//  - out_ch holds a result word in a register until taken; a stalled
//    receiver holds the finished read or run, and the block waits on it.
//  - cfg_ch is always ready: index 0 direction, index 1 log2_points.
//  - Reset clears the control state, the shift count and the registers
//    (direction 0, log2_points 10); the memories stay undefined until written.
`default_nettype none
module block_float_radix2_dif_fft
  import bf_fft_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bf_fft_in_if.sink   in_ch,
  bf_fft_out_if.source out_ch,
  bf_fft_cfg_if.sink  cfg_ch
);

  logic               dir_q, out_valid_q, out_kind_q, out_free, out_load, out_kind;
  logic [3:0]         lg_q, out_shift_q;
  logic signed [15:0] out_re_q, out_im_q, rd_re, rd_im;
  cmd_t               cmd;
  status_t            status;

  // Config writes: always accept, drop indexes beyond the list.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      lg_q  <= 4'd10;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_DIRECTION) dir_q <= cfg_ch.data[0];
      if (cfg_ch.index == REG_LOG2_POINTS) lg_q <= cfg_ch.data;
    end
  end

  bf_fft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_opcode_i (in_ch.opcode),
    .in_index_i  (in_ch.index),
    .in_ready_o  (in_ch.ready),
    .dir_i       (dir_q),
    .lg_i        (lg_q),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_kind_o  (out_kind),
    .cmd_o       (cmd)
  );

  bf_fft_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .ld_re_i  (in_ch.value_re),
    .ld_im_i  (in_ch.value_im),
    .rd_re_o  (rd_re),
    .rd_im_o  (rd_im),
    .status_o (status)
  );

  // Result register: free when empty or being taken this cycle.
  assign out_free = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q  <= out_kind;
      out_re_q    <= (out_kind == KIND_DONE) ? 16'sd0 : rd_re;
      out_im_q    <= (out_kind == KIND_DONE) ? 16'sd0 : rd_im;
      out_shift_q <= status.shift_total;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.result_kind  = out_kind_q;
  assign out_ch.out_re       = out_re_q;
  assign out_ch.out_im       = out_im_q;
  assign out_ch.stage_shifts = out_shift_q;

`ifndef ASSERT_OFF
  // A run holds off further commands on the next cycle.
  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready && (in_ch.opcode == OP_RUN) |=> !in_ch.ready)
    else $error("command accepted straight after a run");

  // A load never raises a result word.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready && !out_ch.valid &&
    ((in_ch.opcode == OP_LOAD_SAMPLE) || (in_ch.opcode == OP_LOAD_TWIDDLE))
    |=> !out_ch.valid)
    else $error("result word raised by a load");

  // The shift count never exceeds the largest stage count.
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.stage_shifts <= LG_MAX)
    else $error("stage shift count out of range");
`endif

endmodule
`default_nettype wire
